// File: rtl/bsmf_pkg.sv
// shared types and constants for the byte stream mode finder
`default_nettype none

package bsmf_pkg;

   localparam int SYM_W   = 8;
   localparam int CNT_W   = 17;
   localparam int RANK_W  = 8;
   localparam int NRANK_W = 9;
   localparam int DEPTH   = 256;

   // operation codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // counts saturate here; the stream length stops at LEN_LIMIT, which is at most this
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // rank saturates once every byte value has appeared
   localparam logic [NRANK_W-1:0] RANK_END = NRANK_W'(DEPTH);

   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [RANK_W-1:0] rank_type;

   // one table entry per byte value
   typedef struct packed {
      cnt_type  count;
      rank_type rank;
   } entry_type;

   // write request into the count table
   typedef struct packed {
      logic      en;
      sym_type   addr;
      entry_type data;
   } tbl_wr_type;

endpackage

`default_nettype wire

// File: rtl/bsmf_table.sv
// per-symbol count and first-rank memory, one write and one registered read port
`default_nettype none

module bsmf_table (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire bsmf_pkg::sym_type   rd_addr,
   input  wire bsmf_pkg::tbl_wr_type wr,
   output bsmf_pkg::entry_type      rd_data
);

   bsmf_pkg::entry_type mem_ff [bsmf_pkg::DEPTH];
   bsmf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read data holds while no new beat is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/byte_stream_mode_finder.sv
// top level of the byte stream mode finder
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------
//   req      | in        | req_valid / req_ready | req_operation, req_symbol
//   rsp      | out       | rsp_valid / rsp_ready | rsp_mode_symbol, rsp_mode_count
//
// one beat per cycle: a beat is taken into the stage register while the count table
// is read, and the next cycle does the count update, table write and best compare.
// the read-modify-write on the table forms a loop; a back-to-back repeat of
// the same symbol takes its count from a forwarding register instead of the memory.
// an append beat in the stage register never waits on rsp; a report beat waits there
// only while an earlier report is still held in the rsp register, and req_ready stays
// low until it moves on.
// reset is synchronous and clears the seen flags and running state; the table itself
// is not cleared, since an entry's data is only used once its seen flag is set.
`default_nettype none

module byte_stream_mode_finder #(
   parameter int MAX_LEN = 65536
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_operation,
   input  wire logic [bsmf_pkg::SYM_W-1:0]  req_symbol,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bsmf_pkg::SYM_W-1:0]       rsp_mode_symbol,
   output logic [bsmf_pkg::CNT_W-1:0]       rsp_mode_count
);

   // effective stream length limit, capped at the count range
   localparam int LIMIT_INT = (MAX_LEN < int'(bsmf_pkg::CNT_MAX)) ?
                              MAX_LEN : int'(bsmf_pkg::CNT_MAX);
   localparam logic [bsmf_pkg::CNT_W-1:0] LEN_LIMIT = bsmf_pkg::CNT_W'(LIMIT_INT);

   // stage register
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_op_ff;
   bsmf_pkg::sym_type       s1_sym_ff;

   // forwarding of the last written entry
   logic                    fwd_ff, fwd_in;
   bsmf_pkg::entry_type     fwd_data_ff;

   // running state
   logic [bsmf_pkg::DEPTH-1:0]   seen_ff, seen_in;
   logic [bsmf_pkg::NRANK_W-1:0] next_rank_ff, next_rank_in;
   bsmf_pkg::cnt_type       length_ff, length_in;
   bsmf_pkg::sym_type       best_sym_ff, best_sym_in;
   bsmf_pkg::cnt_type       best_cnt_ff, best_cnt_in;
   bsmf_pkg::rank_type      best_rank_ff, best_rank_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   bsmf_pkg::sym_type       rsp_sym_ff;
   bsmf_pkg::cnt_type       rsp_cnt_ff;

   logic                    accept;
   logic                    s1_fire;
   logic                    do_append;
   logic                    do_report;
   logic                    sym_seen;
   bsmf_pkg::entry_type     rd_data;
   bsmf_pkg::entry_type     old_entry;
   bsmf_pkg::entry_type     new_entry;
   bsmf_pkg::tbl_wr_type    tbl_wr;
   logic                    take_best;

   // handshake
   assign s1_fire   = s1_valid_ff &&
                      ((s1_op_ff == bsmf_pkg::OP_APPEND) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   assign do_report = s1_fire && (s1_op_ff == bsmf_pkg::OP_REPORT);
   // appends past the length limit are dropped
   assign do_append = s1_fire && (s1_op_ff == bsmf_pkg::OP_APPEND) && (length_ff < LEN_LIMIT);

   bsmf_table u_table (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_symbol),
      .wr      (tbl_wr),
      .rd_data (rd_data)
   );

   // count update for the symbol in the stage register
   always_comb begin
      sym_seen  = seen_ff[s1_sym_ff];
      old_entry = fwd_ff ? fwd_data_ff : rd_data;
      if (!sym_seen) begin
         new_entry.count = bsmf_pkg::CNT_W'(1);
         new_entry.rank  = next_rank_ff[bsmf_pkg::RANK_W-1:0];
      end else begin
         new_entry.count = (old_entry.count < bsmf_pkg::CNT_MAX) ?
                           old_entry.count + bsmf_pkg::CNT_W'(1) : old_entry.count;
         new_entry.rank  = old_entry.rank;
      end
      // higher count wins, an equal count goes to the earlier first appearance
      take_best = (new_entry.count > best_cnt_ff) ||
                  ((new_entry.count == best_cnt_ff) && (new_entry.rank < best_rank_ff));

      tbl_wr.en   = do_append;
      tbl_wr.addr = s1_sym_ff;
      tbl_wr.data = new_entry;
   end

   // next values of the running state
   always_comb begin
      seen_in      = seen_ff;
      next_rank_in = next_rank_ff;
      length_in    = length_ff;
      best_sym_in  = best_sym_ff;
      best_cnt_in  = best_cnt_ff;
      best_rank_in = best_rank_ff;
      if (do_report) begin
         // report clears everything back to the empty stream
         seen_in      = '0;
         next_rank_in = '0;
         length_in    = '0;
         best_sym_in  = '0;
         best_cnt_in  = '0;
         best_rank_in = '0;
      end else if (do_append) begin
         length_in           = length_ff + bsmf_pkg::CNT_W'(1);
         seen_in[s1_sym_ff]  = 1'b1;
         if (!sym_seen && (next_rank_ff < bsmf_pkg::RANK_END)) begin
            next_rank_in = next_rank_ff + bsmf_pkg::NRANK_W'(1);
         end
         if (take_best) begin
            best_sym_in  = s1_sym_ff;
            best_cnt_in  = new_entry.count;
            best_rank_in = new_entry.rank;
         end
      end
   end

   // stage and forwarding control
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
         fwd_in      = do_append && (req_symbol == s1_sym_ff);
      end else begin
         s1_valid_in = s1_fire ? 1'b0 : s1_valid_ff;
         fwd_in      = fwd_ff;
      end
   end

   // result register loads on a report, drains on rsp_ready
   always_comb begin
      if (do_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         seen_ff      <= '0;
         next_rank_ff <= '0;
         length_ff    <= '0;
         best_sym_ff  <= '0;
         best_cnt_ff  <= '0;
         best_rank_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         seen_ff      <= seen_in;
         next_rank_ff <= next_rank_in;
         length_ff    <= length_in;
         best_sym_ff  <= best_sym_in;
         best_cnt_ff  <= best_cnt_in;
         best_rank_ff <= best_rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= req_operation;
         s1_sym_ff <= req_symbol;
      end
      if (do_append) begin
         fwd_data_ff <= new_entry;
      end
      if (do_report) begin
         rsp_sym_ff <= best_sym_ff;
         rsp_cnt_ff <= best_cnt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode_symbol = rsp_sym_ff;
   assign rsp_mode_count  = rsp_cnt_ff;

endmodule

`default_nettype wire

// File: rtl/bsmf_checker.sv
// port-level checks for the byte stream mode finder, bound to the top level
`default_nettype none

module bsmf_checker #(
   parameter int MAX_LEN = 65536
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [bsmf_pkg::SYM_W-1:0]  rsp_mode_symbol,
   input wire logic [bsmf_pkg::CNT_W-1:0]  rsp_mode_count
);

   localparam int LIMIT_INT = (MAX_LEN < int'(bsmf_pkg::CNT_MAX)) ?
                              MAX_LEN : int'(bsmf_pkg::CNT_MAX);
   localparam logic [bsmf_pkg::CNT_W-1:0] LEN_LIMIT = bsmf_pkg::CNT_W'(LIMIT_INT);

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a held result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_symbol) &&
                                  $stable(rsp_mode_count))
      else $error("stalled result beat changed");

   // an empty stream reports symbol zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_count == '0) |-> rsp_mode_symbol == '0)
      else $error("empty stream reported a nonzero symbol");

   // a mode count never exceeds the stream length limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_count <= LEN_LIMIT)
      else $error("mode count above length limit");

endmodule

bind byte_stream_mode_finder bsmf_checker #(.MAX_LEN(MAX_LEN)) u_bsmf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_mode_symbol (rsp_mode_symbol),
   .rsp_mode_count  (rsp_mode_count)
);

`default_nettype wire
